@@ design/ccv_pkg.sv @@
`timescale 1ns / 1ps
package ccv_pkg;

  localparam int SUM_W = 20;
  localparam int NUM_W = 27;
  localparam int DIV_CNT_W = 5;
  localparam logic [7:0] CH_MAX = 8'd255;

  localparam logic [2:0] CFG_KERNEL_UPPER = 3'd0;
  localparam logic [2:0] CFG_KERNEL_LOWER = 3'd1;
  localparam logic [2:0] CFG_NORM = 3'd2;
  localparam logic [2:0] CFG_WIDTH = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last_of_run;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_TAP,
    ST_LAST,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } state_t;

  function automatic logic [1:0] inc3(input logic [1:0] m);
    return (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] m);
    return (m == 2'd0) ? 2'd2 : m - 2'd1;
  endfunction

  function automatic logic signed [7:0] coef(input logic [3:0] k, input logic [47:0] up,
                                             input logic [23:0] lo);
    logic signed [7:0] c;
    case (k)
      4'd0: c = up[7:0];
      4'd1: c = up[15:8];
      4'd2: c = up[23:16];
      4'd3: c = up[31:24];
      4'd4: c = up[39:32];
      4'd5: c = up[47:40];
      4'd6: c = lo[7:0];
      4'd7: c = lo[15:8];
      4'd8: c = lo[23:16];
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ design/ccv_ram.sv @@
`timescale 1ns / 1ps
module ccv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/ccv_div.sv @@
`timescale 1ns / 1ps
module ccv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ccv_pkg::NUM_W-1:0]  num,
  input  logic [15:0]                den,
  output logic                       done,
  output logic [7:0]                 quo
);

  logic [15:0]                     rem_r;
  logic [ccv_pkg::NUM_W-1:0]       quo_r;
  logic [ccv_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [16:0]                     shifted;
  logic                            take;

  assign shifted = {rem_r, quo_r[ccv_pkg::NUM_W-1]};
  assign take = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      cnt_r <= ccv_pkg::DIV_CNT_W'(ccv_pkg::NUM_W - 1);
    end else if (busy_r) begin
      rem_r <= take ? 16'(shifted - {1'b0, den}) : shifted[15:0];
      quo_r <= {quo_r[ccv_pkg::NUM_W-2:0], take};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo = (|quo_r[ccv_pkg::NUM_W-1:8]) ? ccv_pkg::CH_MAX : quo_r[7:0];

endmodule

@@ design/convolve_3x3_rgba.sv @@
`timescale 1ns / 1ps
// each accepted word releases zero to four outputs; the next word is not taken until all of them
//   are computed and loaded (loading stalls while out_ready is low and an output is still held)
// each output takes 9 reads of the single-port line store, then a pass of the 27-step divider
// reset: synchronous active-low rst_n clears position counters, control and config registers to defaults
// line store holds no reset value; entries are read only after being written
module convolve_3x3_rgba #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccv_pkg::pix_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccv_pkg::res_t       out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = ccv_pkg::SUM_W;

  ccv_pkg::state_t state_r, state_nxt;

  logic [47:0] kup_r;
  logic [23:0] klo_r;
  logic [15:0] norm_r;
  logic [10:0] img_w_r;
  logic [15:0] img_h_r;

  logic [15:0]   in_row_r;
  logic [1:0]    in_m3_r;
  logic [CW-1:0] in_col_r;

  logic [15:0]   jr_r;
  logic [1:0]    jm3_r;
  logic [CW-1:0] jc_r;
  logic [3:0]    flags_r;

  logic [15:0]   oi_r;
  logic [CW-1:0] oj_r;
  logic          last_r;
  logic [1:0]    bank_r [3];
  logic [CW-1:0] col_r [3];
  logic [1:0]    ta_r, tb_r;
  logic [3:0]    tap_r, tap_d_r;
  logic          acc_en_r;
  logic signed [SW-1:0] acc_r [4];

  ccv_pkg::res_t out_r;
  logic          out_valid_r;

  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [15:0]   cur_r;
  logic [1:0]    cur_m3;
  logic [CW-1:0] cur_c;
  logic          c_last, r_last, accept;

  logic          ram_we, div_start, out_load;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  logic [3:0]    div_done;
  logic [7:0]    div_quo [4];
  logic [7:0]    chan [4];

  logic [1:0]    sel;
  logic [3:0]    flags_left;
  logic [15:0]   si;
  logic [1:0]    sm3;
  logic [CW-1:0] sj;
  logic [15:0]   den;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kup_r <= 48'h010101010101;
      klo_r <= 24'h010101;
      norm_r <= 16'd2304;
      img_w_r <= 11'd1024;
      img_h_r <= 16'd768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccv_pkg::CFG_KERNEL_UPPER: kup_r <= cfg_data;
        ccv_pkg::CFG_KERNEL_LOWER: klo_r <= cfg_data[23:0];
        ccv_pkg::CFG_NORM:         norm_r <= cfg_data[15:0];
        ccv_pkg::CFG_WIDTH:        img_w_r <= cfg_data[10:0];
        ccv_pkg::CFG_HEIGHT:       img_h_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w_r);
    end
    h_eff = (img_h_r == '0) ? 16'd1 : img_h_r;
  end

  // position of the arriving word, wrapped if the frame shrank
  assign cur_r  = (in_row_r >= h_eff) ? 16'd0 : in_row_r;
  assign cur_m3 = (in_row_r >= h_eff) ? 2'd0 : in_m3_r;
  assign cur_c  = (WW'(in_col_r) >= w_eff) ? '0 : in_col_r;
  assign c_last = WW'(cur_c) == w_eff - 1'b1;
  assign r_last = cur_r == h_eff - 1'b1;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccv_pkg::ST_IDLE:  if (in_valid) state_nxt = ccv_pkg::ST_NEXT;
      ccv_pkg::ST_NEXT:  state_nxt = (flags_r == '0) ? ccv_pkg::ST_IDLE : ccv_pkg::ST_TAP;
      ccv_pkg::ST_TAP:   if (ta_r == 2'd2 && tb_r == 2'd2) state_nxt = ccv_pkg::ST_LAST;
      ccv_pkg::ST_LAST:  state_nxt = ccv_pkg::ST_DIVGO;
      ccv_pkg::ST_DIVGO: state_nxt = ccv_pkg::ST_DIV;
      ccv_pkg::ST_DIV:   if (div_done[0]) state_nxt = ccv_pkg::ST_OUT;
      ccv_pkg::ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ccv_pkg::ST_NEXT;
      default:           state_nxt = ccv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ccv_pkg::ST_IDLE:  in_ready = 1'b1;
      ccv_pkg::ST_DIVGO: div_start = 1'b1;
      ccv_pkg::ST_OUT:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign ram_we = accept;
  assign ram_addr = accept
      ? AW'(cur_m3) * AW'(MAX_WIDTH) + AW'(cur_c)
      : AW'(bank_r[ta_r]) * AW'(MAX_WIDTH) + AW'(col_r[tb_r]);

  ccv_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_m3_r <= '0;
      in_col_r <= '0;
      flags_r <= '0;
    end else if (accept) begin
      jr_r <= cur_r;
      jm3_r <= cur_m3;
      jc_r <= cur_c;
      flags_r <= {r_last && c_last, r_last && cur_c != '0,
                  cur_r != '0 && c_last, cur_r != '0 && cur_c != '0};
      if (c_last) begin
        in_col_r <= '0;
        in_row_r <= r_last ? 16'd0 : cur_r + 16'd1;
        in_m3_r <= r_last ? 2'd0 : ccv_pkg::inc3(cur_m3);
      end else begin
        in_col_r <= cur_c + 1'b1;
        in_row_r <= cur_r;
        in_m3_r <= cur_m3;
      end
    end else if (state_r == ccv_pkg::ST_NEXT) begin
      flags_r <= flags_left;
    end
  end

  // pick the next pending output in raster order
  always_comb begin
    if (flags_r[0]) begin
      sel = 2'd0;
    end else if (flags_r[1]) begin
      sel = 2'd1;
    end else if (flags_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    flags_left = flags_r & ~(4'd1 << sel);
    si  = sel[1] ? jr_r : jr_r - 16'd1;
    sm3 = sel[1] ? jm3_r : ccv_pkg::dec3(jm3_r);
    sj  = sel[0] ? jc_r : jc_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state_r == ccv_pkg::ST_NEXT) begin
      oi_r <= si;
      oj_r <= sj;
      last_r <= flags_left == '0;
      bank_r[0] <= (si != '0) ? ccv_pkg::dec3(sm3) : sm3;
      bank_r[1] <= sm3;
      bank_r[2] <= (17'(si) + 17'd1 < 17'(h_eff)) ? ccv_pkg::inc3(sm3) : sm3;
      col_r[0] <= (sj != '0) ? sj - 1'b1 : sj;
      col_r[1] <= sj;
      col_r[2] <= (WW'(sj) + 1'b1 < w_eff) ? sj + 1'b1 : sj;
      ta_r <= '0;
      tb_r <= '0;
      tap_r <= '0;
    end else if (state_r == ccv_pkg::ST_TAP) begin
      tb_r <= (tb_r == 2'd2) ? 2'd0 : tb_r + 2'd1;
      ta_r <= (tb_r == 2'd2 && ta_r != 2'd2) ? ta_r + 2'd1 : ta_r;
      tap_r <= tap_r + 4'd1;
    end
    tap_d_r <= tap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= state_r == ccv_pkg::ST_TAP;
    end
  end

  for (genvar ch = 0; ch < 4; ch++) begin : g_lane
    logic signed [16:0] prod;
    logic [SW-1:0]      mag;

    assign prod = ccv_pkg::coef(tap_d_r, kup_r, klo_r)
                * $signed({1'b0, ram_rdata[8*(3-ch) +: 8]});
    assign mag = acc_r[ch][SW-1] ? SW'(-acc_r[ch]) : SW'(acc_r[ch]);

    always_ff @(posedge clk) begin
      if (state_r == ccv_pkg::ST_NEXT) begin
        acc_r[ch] <= '0;
      end else if (acc_en_r) begin
        acc_r[ch] <= acc_r[ch] + {{(SW-17){prod[16]}}, prod};
      end
    end

    ccv_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   ({mag[SW-2:0], 8'd0}),
      .den   (den),
      .done  (div_done[ch]),
      .quo   (div_quo[ch])
    );

    assign chan[ch] = (norm_r == '0 || acc_r[ch][SW-1] != norm_r[15]) ? 8'd0 : div_quo[ch];
  end

  assign den = norm_r[15] ? 16'(-norm_r) : norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.red <= chan[0];
      out_r.green <= chan[1];
      out_r.blue <= chan[2];
      out_r.alpha <= chan[3];
      out_r.row <= oi_r;
      out_r.col <= 10'(oj_r);
      out_r.last_of_run <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ccv_pkg::ST_IDLE |-> flags_r == '0)
    else $error("pending outputs left while idle");

  a_accept_to_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ccv_pkg::ST_NEXT && !in_ready)
    else $error("word accepted without starting its outputs");

  a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ccv_pkg::ST_DIV && div_done[0] |-> div_done == 4'hF)
    else $error("divider lanes out of step");
`endif

endmodule
